[rtl/core/djtt_pkg.sv]
// ----------------------------------------------------------------------------
// djtt_pkg
// Shared types and constants of the delayed job timer table.
// ----------------------------------------------------------------------------
package djtt_pkg;

  // Table size default and per-tick result limit
  localparam int unsigned MaxJobsDef = 16;
  localparam int unsigned MaxResults = 16;

  // Field widths
  localparam int unsigned HandleW = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsTickW = 10;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register map, as word index
  localparam logic REG_MS_PER_TICK = 1'b0;
  localparam logic [MsTickW-1:0] MsPerTickRst = MsTickW'(1);

  // Operation codes of an input word
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_FLUSH = 2'd2
  } djtt_func_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_FLUSH   = 2'd2
  } djtt_kind_e;

  // Status codes
  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_BUSY = 1'b1
  } djtt_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK_RD,
    ST_TICK_UPD,
    ST_TICK_END,
    ST_FLUSH
  } djtt_state_e;

  // Input word
  typedef struct packed {
    logic [1:0]         func;
    logic [HandleW-1:0] job_handle;
    logic [TimeW-1:0]   job_delay;
  } djtt_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]         result_kind;
    logic               status_code;
    logic [HandleW-1:0] expired_handle;
    logic               last_of_run;
  } djtt_out_t;

  // One table entry held in memory
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   remaining;
  } djtt_entry_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    djtt_entry_t wr_data;
  } djtt_mem_req_t;

endpackage

[rtl/core/delayed_job_timer_table_unit.sv]
// ----------------------------------------------------------------------------
// delayed_job_timer_table_unit
// Table of delayed jobs with add, tick and flush operations.
// ----------------------------------------------------------------------------
// Input words carry func, job_handle and job_delay; a word moves when
// in_valid_i is high and in_stall_o low. Result words leave through a
// register on out_valid_o / out_stall_i and are held while stalled.
// Add gives one status word, flush one done word, tick one word per
// expiring job up to MaxResults, in ascending slot order with
// last_of_run on the final one, or nothing when no job expires.
// One word is worked on at a time; in_stall_o is high until it is done.
// The sequencer walks the slots one per cycle, but in a tick an active
// slot also takes an update step after its entry memory read, and a step
// that loads a result waits while the result register is blocked. A
// result waiting in the output register does not block the next input
// word, but a new result waits while the receiver stalls. After reset
// every slot is free and ms_per_tick is 1; no clearing pass is needed.
// ms_per_tick is set over the APB port; the user must set it only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module delayed_job_timer_table_unit
  import djtt_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  djtt_in_t            in_data_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output djtt_out_t           out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  logic [MsTickW-1:0] ms_per_tick;
  logic [IdxW-1:0]    mem_addr;
  djtt_mem_req_t      mem_req;
  djtt_entry_t        mem_rd_data;

  djtt_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .ms_per_tick_o (ms_per_tick)
  );

  djtt_ctrl #(
    .MAX_JOBS (MAX_JOBS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .ms_per_tick_i (ms_per_tick),
    .mem_addr_o    (mem_addr),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data)
  );

  djtt_mem #(
    .MAX_JOBS (MAX_JOBS)
  ) u_mem (
    .clk_i     (clk_i),
    .addr_i    (mem_addr),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

endmodule

[rtl/core/djtt_mem.sv]
// ----------------------------------------------------------------------------
// djtt_mem
// Entry store: handle and remaining time per slot, one port, registered read.
// ----------------------------------------------------------------------------
module djtt_mem
  import djtt_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobsDef,
  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
  input  logic            clk_i,
  input  logic [IdxW-1:0] addr_i,
  input  djtt_mem_req_t   req_i,
  output djtt_entry_t     rd_data_o
);

  djtt_entry_t mem_q [MAX_JOBS];
  djtt_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[addr_i] <= req_i.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/djtt_cfg.sv]
// ----------------------------------------------------------------------------
// djtt_cfg
// APB register block holding the tick length in milliseconds.
// ----------------------------------------------------------------------------
module djtt_cfg
  import djtt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [MsTickW-1:0]  ms_per_tick_o
);

  logic [MsTickW-1:0] ms_per_tick_q, ms_per_tick_d;
  logic               wr_hit;

  // word index sits above the byte offset
  assign wr_hit = psel && penable && pwrite && (paddr[ApbAddrW-1] == REG_MS_PER_TICK);

  always_comb begin
    ms_per_tick_d = ms_per_tick_q;
    if (wr_hit) begin
      ms_per_tick_d = pwdata[MsTickW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_tick_q <= MsPerTickRst;
    end else begin
      ms_per_tick_q <= ms_per_tick_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1] == REG_MS_PER_TICK) begin
      prdata = ApbDataW'(ms_per_tick_q);
    end
  end

  assign pready        = 1'b1;
  assign ms_per_tick_o = ms_per_tick_q;

endmodule

[rtl/core/djtt_ctrl.sv]
// ----------------------------------------------------------------------------
// djtt_ctrl
// Sequencer: slot walk for add and tick, active flags, result register.
// ----------------------------------------------------------------------------
module djtt_ctrl
  import djtt_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobsDef,
  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1),
  localparam int unsigned ExpW = $clog2(MaxResults + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  djtt_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output djtt_out_t          out_data_o,
  input  logic [MsTickW-1:0] ms_per_tick_i,
  output logic [IdxW-1:0]    mem_addr_o,
  output djtt_mem_req_t      mem_req_o,
  input  djtt_entry_t        mem_rd_data_i
);

  djtt_state_e        state_q, state_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [ExpW-1:0]    nexp_q, nexp_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [TimeW-1:0]   delay_q, delay_d;
  logic [MAX_JOBS-1:0] active_q, active_d;
  logic               pend_valid_q, pend_valid_d;
  logic [HandleW-1:0] pend_handle_q, pend_handle_d;
  logic               out_valid_q, out_valid_d;
  djtt_out_t          out_q, out_d;

  logic [IdxW-1:0]    idx;
  logic               at_end;
  logic               can_load;
  logic               load_out;
  djtt_out_t          out_new;
  logic [TimeW-1:0]   tick_len;

  assign idx      = idx_q[IdxW-1:0];
  assign at_end   = (idx_q == CntW'(MAX_JOBS));
  assign can_load = !out_valid_q || !out_stall_i;
  assign tick_len = TimeW'(ms_per_tick_i);

  // next state and datapath control
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    nexp_d        = nexp_q;
    handle_d      = handle_q;
    delay_d       = delay_q;
    active_d      = active_q;
    pend_valid_d  = pend_valid_q;
    pend_handle_d = pend_handle_q;
    load_out      = 1'b0;
    out_new       = '0;
    mem_req_o     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          handle_d = in_data_i.job_handle;
          delay_d  = in_data_i.job_delay;
          idx_d    = '0;
          nexp_d   = '0;
          case (in_data_i.func)
            FUNC_ADD:   state_d = ST_ADD;
            FUNC_TICK:  state_d = ST_TICK_RD;
            FUNC_FLUSH: state_d = ST_FLUSH;
            default:    state_d = ST_IDLE;
          endcase
        end
      end

      // look for the lowest free slot, one per cycle; taking it waits on can_load
      ST_ADD: begin
        if (at_end) begin
          if (can_load) begin
            load_out               = 1'b1;
            out_new.result_kind    = KIND_ADD;
            out_new.status_code    = STATUS_BUSY;
            out_new.last_of_run    = 1'b1;
            state_d                = ST_IDLE;
          end
        end else if (active_q[idx]) begin
          idx_d = idx_q + CntW'(1);
        end else if (can_load) begin
          mem_req_o.wr_en             = 1'b1;
          mem_req_o.wr_data.handle    = handle_q;
          mem_req_o.wr_data.remaining = delay_q;
          active_d[idx]               = 1'b1;
          load_out                    = 1'b1;
          out_new.result_kind         = KIND_ADD;
          out_new.status_code         = STATUS_OK;
          out_new.last_of_run         = 1'b1;
          state_d                     = ST_IDLE;
        end
      end

      // skip idle slots, fetch active ones
      ST_TICK_RD: begin
        if (at_end) begin
          state_d = ST_TICK_END;
        end else if (active_q[idx]) begin
          mem_req_o.rd_en = 1'b1;
          state_d         = ST_TICK_UPD;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      // count down or release (past the result limit, leave in place); an expiry
      // waits for the next one or the end so the final one can carry last_of_run
      ST_TICK_UPD: begin
        if (tick_len <= mem_rd_data_i.remaining) begin
          mem_req_o.wr_en             = 1'b1;
          mem_req_o.wr_data.handle    = mem_rd_data_i.handle;
          mem_req_o.wr_data.remaining = mem_rd_data_i.remaining - tick_len;
          idx_d                       = idx_q + CntW'(1);
          state_d                     = ST_TICK_RD;
        end else if (nexp_q == ExpW'(MaxResults)) begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_TICK_RD;
        end else if (!pend_valid_q || can_load) begin
          if (pend_valid_q) begin
            load_out               = 1'b1;
            out_new.result_kind    = KIND_EXPIRED;
            out_new.status_code    = STATUS_OK;
            out_new.expired_handle = pend_handle_q;
            out_new.last_of_run    = 1'b0;
          end
          pend_valid_d  = 1'b1;
          pend_handle_d = mem_rd_data_i.handle;
          active_d[idx] = 1'b0;
          nexp_d        = nexp_q + ExpW'(1);
          idx_d         = idx_q + CntW'(1);
          state_d       = ST_TICK_RD;
        end
      end

      // flush out the held expiry as the final word
      ST_TICK_END: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_load) begin
          load_out               = 1'b1;
          out_new.result_kind    = KIND_EXPIRED;
          out_new.status_code    = STATUS_OK;
          out_new.expired_handle = pend_handle_q;
          out_new.last_of_run    = 1'b1;
          pend_valid_d           = 1'b0;
          state_d                = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (can_load) begin
          active_d            = '0;
          load_out            = 1'b1;
          out_new.result_kind = KIND_FLUSH;
          out_new.status_code = STATUS_OK;
          out_new.last_of_run = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = out_new;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      nexp_q       <= '0;
      active_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      nexp_q       <= nexp_d;
      active_q     <= active_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    handle_q      <= handle_d;
    delay_q       <= delay_d;
    pend_handle_q <= pend_handle_d;
    out_q         <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mem_addr_o  = idx;

endmodule
